FILE: rtl/qrm_pkg.sv
`default_nettype none

package qrm_pkg;

    localparam int N_ENT     = 9;
    localparam int ENT_W     = 16;
    localparam int QUO_W     = 16;
    localparam int DIV_STEPS = 15;
    localparam int M_TDATA_W = N_ENT * ENT_W;

    localparam logic [ENT_W-1:0] ONE_Q14 = 16'h4000;
    localparam logic [ENT_W-1:0] ZERO_Q14 = 16'h0000;

    // r00 in the lowest bits, r22 in the highest
    localparam logic [M_TDATA_W-1:0] IDENTITY_DATA = {
        ONE_Q14, ZERO_Q14, ZERO_Q14,
        ZERO_Q14, ONE_Q14, ZERO_Q14,
        ZERO_Q14, ZERO_Q14, ONE_Q14
    };

    typedef struct packed {
        logic valid;
        logic zero;
    } qrm_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/qrm_terms.sv
`default_nettype none

module qrm_terms #(
    parameter int COMPONENT_BITS = 16,
    localparam int PW = 2 * COMPONENT_BITS,
    localparam int SW = 2 * COMPONENT_BITS + 2,
    localparam int NW = 2 * COMPONENT_BITS + 1,
    localparam int RW = 2 * COMPONENT_BITS + 2
)
(
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           en,
    input  wire logic                                           in_valid,
    input  wire logic [4*COMPONENT_BITS-1:0]                    in_data,
    output qrm_pkg::qrm_ctl_t                                   out_ctl,
    output logic [NW-1:0]                                       out_n,
    output logic [qrm_pkg::N_ENT-1:0]                           out_sign,
    output logic [qrm_pkg::N_ENT-1:0][RW-1:0]                   out_rem,
    output logic [qrm_pkg::N_ENT-1:0][qrm_pkg::QUO_W-1:0]       out_quo
);

    import qrm_pkg::*;

    localparam int B = COMPONENT_BITS;

    logic signed [B-1:0] cx, cy, cz, cw;

    logic signed [PW-1:0] xx_next, yy_next, zz_next, ww_next;
    logic signed [PW-1:0] xy_next, xz_next, yz_next, xw_next, yw_next, zw_next;
    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PW-1:0] xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    qrm_ctl_t             ctl_a_reg;

    logic signed [SW-1:0] n_sum;
    logic signed [SW-1:0] num_next [N_ENT];
    logic signed [SW-1:0] num_reg  [N_ENT];
    logic [NW-1:0]        n_b_reg;
    qrm_ctl_t             ctl_b_reg;

    logic [NW-1:0]        mag      [N_ENT];
    logic [N_ENT-1:0]     sign_next;
    logic [N_ENT-1:0][RW-1:0]    rem_next;
    logic [N_ENT-1:0][QUO_W-1:0] quo_next;
    logic [NW-1:0]        n_c_reg;
    logic [N_ENT-1:0]     sign_reg;
    logic [N_ENT-1:0][RW-1:0]    rem_reg;
    logic [N_ENT-1:0][QUO_W-1:0] quo_reg;
    qrm_ctl_t             ctl_c_reg;

    assign cx = in_data[B-1:0];
    assign cy = in_data[2*B-1:B];
    assign cz = in_data[3*B-1:2*B];
    assign cw = in_data[4*B-1:3*B];

    // stage A: the ten products
    assign xx_next = PW'(cx) * PW'(cx);
    assign yy_next = PW'(cy) * PW'(cy);
    assign zz_next = PW'(cz) * PW'(cz);
    assign ww_next = PW'(cw) * PW'(cw);
    assign xy_next = PW'(cx) * PW'(cy);
    assign xz_next = PW'(cx) * PW'(cz);
    assign yz_next = PW'(cy) * PW'(cz);
    assign xw_next = PW'(cx) * PW'(cw);
    assign yw_next = PW'(cy) * PW'(cw);
    assign zw_next = PW'(cz) * PW'(cw);

    // stage B: norm and the nine numerators
    assign n_sum = SW'(xx_reg) + SW'(yy_reg) + SW'(zz_reg) + SW'(ww_reg);

    always_comb
    begin
        num_next[0] = SW'(ww_reg) + SW'(xx_reg) - SW'(yy_reg) - SW'(zz_reg);
        num_next[1] = (SW'(xy_reg) - SW'(zw_reg)) <<< 1;
        num_next[2] = (SW'(xz_reg) + SW'(yw_reg)) <<< 1;
        num_next[3] = (SW'(xy_reg) + SW'(zw_reg)) <<< 1;
        num_next[4] = SW'(ww_reg) + SW'(yy_reg) - SW'(xx_reg) - SW'(zz_reg);
        num_next[5] = (SW'(yz_reg) - SW'(xw_reg)) <<< 1;
        num_next[6] = (SW'(xz_reg) - SW'(yw_reg)) <<< 1;
        num_next[7] = (SW'(yz_reg) + SW'(xw_reg)) <<< 1;
        num_next[8] = SW'(ww_reg) + SW'(zz_reg) - SW'(xx_reg) - SW'(yy_reg);
    end

    // stage C: split into sign and magnitude; a magnitude equal to the norm
    // gives the leading quotient bit
    always_comb
    begin
        for (int k = 0; k < N_ENT; k++)
        begin
            sign_next[k] = num_reg[k][SW-1];
            mag[k] = num_reg[k][SW-1] ? NW'(-num_reg[k]) : NW'(num_reg[k]);
            if (mag[k] == n_b_reg)
            begin
                rem_next[k] = '0;
                quo_next[k] = QUO_W'(1);
            end
            else
            begin
                rem_next[k] = RW'(mag[k]);
                quo_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= '{valid: in_valid, zero: 1'b0};
            ctl_b_reg <= '{valid: ctl_a_reg.valid, zero: (n_sum == '0)};
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            zz_reg <= zz_next;
            ww_reg <= ww_next;
            xy_reg <= xy_next;
            xz_reg <= xz_next;
            yz_reg <= yz_next;
            xw_reg <= xw_next;
            yw_reg <= yw_next;
            zw_reg <= zw_next;
            n_b_reg <= n_sum[NW-1:0];
            for (int k = 0; k < N_ENT; k++)
            begin
                num_reg[k] <= num_next[k];
            end
            n_c_reg  <= n_b_reg;
            sign_reg <= sign_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign out_ctl  = ctl_c_reg;
    assign out_n    = n_c_reg;
    assign out_sign = sign_reg;
    assign out_rem  = rem_reg;
    assign out_quo  = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/qrm_div_step.sv
`default_nettype none

module qrm_div_step #(
    parameter int COMPONENT_BITS = 16,
    localparam int NW = 2 * COMPONENT_BITS + 1,
    localparam int RW = 2 * COMPONENT_BITS + 2
)
(
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           en,
    input  qrm_pkg::qrm_ctl_t                                   in_ctl,
    input  wire logic [NW-1:0]                                  in_n,
    input  wire logic [qrm_pkg::N_ENT-1:0]                      in_sign,
    input  wire logic [qrm_pkg::N_ENT-1:0][RW-1:0]              in_rem,
    input  wire logic [qrm_pkg::N_ENT-1:0][qrm_pkg::QUO_W-1:0]  in_quo,
    output qrm_pkg::qrm_ctl_t                                   out_ctl,
    output logic [NW-1:0]                                       out_n,
    output logic [qrm_pkg::N_ENT-1:0]                           out_sign,
    output logic [qrm_pkg::N_ENT-1:0][RW-1:0]                   out_rem,
    output logic [qrm_pkg::N_ENT-1:0][qrm_pkg::QUO_W-1:0]       out_quo
);

    import qrm_pkg::*;

    logic [N_ENT-1:0][RW-1:0]    shifted;
    logic [N_ENT-1:0]            fits;
    logic [N_ENT-1:0][RW-1:0]    rem_next;
    logic [N_ENT-1:0][QUO_W-1:0] quo_next;

    qrm_ctl_t                    ctl_reg;
    logic [NW-1:0]               n_reg;
    logic [N_ENT-1:0]            sign_reg;
    logic [N_ENT-1:0][RW-1:0]    rem_reg;
    logic [N_ENT-1:0][QUO_W-1:0] quo_reg;

    // one restoring step on every lane; the remainder stays below the norm,
    // so the bit dropped by the shift is always zero
    always_comb
    begin
        for (int k = 0; k < N_ENT; k++)
        begin
            shifted[k]  = {in_rem[k][RW-2:0], 1'b0};
            fits[k]     = (shifted[k] >= RW'(in_n));
            rem_next[k] = fits[k] ? (shifted[k] - RW'(in_n)) : shifted[k];
            quo_next[k] = {in_quo[k][QUO_W-2:0], fits[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= in_n;
            sign_reg <= in_sign;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_n    = n_reg;
    assign out_sign = sign_reg;
    assign out_rem  = rem_reg;
    assign out_quo  = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/qrm_round.sv
`default_nettype none

module qrm_round
(
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           en,
    input  qrm_pkg::qrm_ctl_t                                   in_ctl,
    input  wire logic [qrm_pkg::N_ENT-1:0]                      in_sign,
    input  wire logic [qrm_pkg::N_ENT-1:0][qrm_pkg::QUO_W-1:0]  in_quo,
    output logic                                                out_valid,
    output logic [qrm_pkg::M_TDATA_W-1:0]                       out_data,
    output logic                                                out_zero
);

    import qrm_pkg::*;

    logic [N_ENT-1:0][QUO_W:0]   rounded;
    logic [N_ENT-1:0][ENT_W-1:0] entry_mag;
    logic [N_ENT-1:0][ENT_W-1:0] entry_val;
    logic [M_TDATA_W-1:0]        data_next;

    logic                        valid_reg;
    logic                        zero_reg;
    logic [M_TDATA_W-1:0]        data_reg;

    // round half away from zero on the magnitude, clamp to one, restore sign
    always_comb
    begin
        for (int k = 0; k < N_ENT; k++)
        begin
            rounded[k]   = ((QUO_W + 1)'(in_quo[k]) + (QUO_W + 1)'(1)) >> 1;
            entry_mag[k] = (rounded[k] > (QUO_W + 1)'(ONE_Q14)) ? ONE_Q14
                                                                 : rounded[k][ENT_W-1:0];
            entry_val[k] = in_sign[k] ? (ENT_W'(0) - entry_mag[k]) : entry_mag[k];
        end
        data_next = in_ctl.zero ? IDENTITY_DATA : M_TDATA_W'(entry_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            zero_reg <= in_ctl.zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_zero  = zero_reg;

endmodule

`default_nettype wire

FILE: rtl/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix. Each input transaction carries one
// quaternion (x, y, z, w, signed, COMPONENT_BITS each) and yields one output
// transaction with the nine entries in signed Q2.14, each the exact ratio of
// its polynomial to the squared norm, rounded to nearest (ties away from
// zero). Non-unit quaternions are fine; an all-zero quaternion gives the
// identity and raises tuser. Unless the output stalls, the pipeline takes one
// transaction every cycle. Its stages: products, sums, sign split, fifteen
// one-bit restoring divide stages that run the nine divisions side by side,
// and the rounding stage that doubles as the output register. A stall at the
// output freezes the whole pipeline; no transaction is lost or repeated.
`default_nettype none

module quaternion_to_rotation_matrix #(
    parameter int COMPONENT_BITS = 16,
    localparam int S_TDATA_W = ((4 * COMPONENT_BITS + 7) / 8) * 8,
    localparam int NW = 2 * COMPONENT_BITS + 1,
    localparam int RW = 2 * COMPONENT_BITS + 2
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // q_x, q_y, q_z, q_w from bit 0 up, zero pad on top
    input  wire logic [S_TDATA_W-1:0]           s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up
    output logic [qrm_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // zero_norm
    output logic                                m_axis_tuser
);

    import qrm_pkg::*;

    logic en;

    qrm_ctl_t                    ctl_s  [DIV_STEPS+1];
    logic [NW-1:0]               n_s    [DIV_STEPS+1];
    logic [N_ENT-1:0]            sign_s [DIV_STEPS+1];
    logic [N_ENT-1:0][RW-1:0]    rem_s  [DIV_STEPS+1];
    logic [N_ENT-1:0][QUO_W-1:0] quo_s  [DIV_STEPS+1];

    // advance everything whenever the output register is free or being drained
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    qrm_terms #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_terms (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata[4*COMPONENT_BITS-1:0]),
        .out_ctl  (ctl_s[0]),
        .out_n    (n_s[0]),
        .out_sign (sign_s[0]),
        .out_rem  (rem_s[0]),
        .out_quo  (quo_s[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        qrm_div_step #(
            .COMPONENT_BITS (COMPONENT_BITS)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_ctl   (ctl_s[i]),
            .in_n     (n_s[i]),
            .in_sign  (sign_s[i]),
            .in_rem   (rem_s[i]),
            .in_quo   (quo_s[i]),
            .out_ctl  (ctl_s[i+1]),
            .out_n    (n_s[i+1]),
            .out_sign (sign_s[i+1]),
            .out_rem  (rem_s[i+1]),
            .out_quo  (quo_s[i+1])
        );
    end

    qrm_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctl    (ctl_s[DIV_STEPS]),
        .in_sign   (sign_s[DIV_STEPS]),
        .in_quo    (quo_s[DIV_STEPS]),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_zero  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_zero_identity : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == IDENTITY_DATA)
        else $error("zero quaternion did not give the identity");

    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipeline stalled with an empty output register");

    for (genvar e = 0; e < N_ENT; e++)
    begin : g_chk
        a_entry_range : assert property (@(posedge clk) disable iff (!rst_n)
            m_axis_tvalid |->
                ($signed(m_axis_tdata[e*ENT_W +: ENT_W]) <= $signed(ONE_Q14)) &&
                ($signed(m_axis_tdata[e*ENT_W +: ENT_W]) >= -$signed(ONE_Q14)))
            else $error("matrix entry beyond plus or minus one");
    end
`endif

endmodule

`default_nettype wire

FILE: test/tb_quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix;
    import qrm_pkg::*;

    localparam int COMP_W       = 16;
    localparam int S_W          = 4 * COMP_W;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    // r00 in ent[0] up to r22 in ent[8], the same order as m_axis_tdata
    typedef struct packed {
        logic                        zero;
        logic [N_ENT-1:0][ENT_W-1:0] ent;
    } rot_mat_t;

    class matrix_board;
        rot_mat_t pending_mats[$];
        int       mismatches = 0;
        int       noted      = 0;
        int       zero_noted = 0;
        int       checked    = 0;

        // round(num * 2^14 / nrm), ties away from zero, limited to plus or minus one
        function logic [ENT_W-1:0] ratio_q14(longint num, longint nrm);
            longint mg;
            longint q;
            mg = (num < 0) ? -num : num;
            if (mg > nrm) begin
                q = ONE_Q14;
            end
            else begin
                q = (mg <<< 15) / nrm;
                q = (q + 1) >>> 1;
                if (q > ONE_Q14)
                    q = ONE_Q14;
            end
            if (num < 0)
                q = -q;
            return ENT_W'(q);
        endfunction

        function void note_quat(logic [S_W-1:0] d);
            longint   x;
            longint   y;
            longint   z;
            longint   w;
            longint   nrm;
            longint   num[N_ENT];
            rot_mat_t m;
            x = longint'($signed(d[COMP_W-1:0]));
            y = longint'($signed(d[2*COMP_W-1:COMP_W]));
            z = longint'($signed(d[3*COMP_W-1:2*COMP_W]));
            w = longint'($signed(d[4*COMP_W-1:3*COMP_W]));
            nrm = x*x + y*y + z*z + w*w;
            noted++;
            if (nrm == 0) begin
                m.ent    = '0;
                m.ent[0] = ONE_Q14;
                m.ent[4] = ONE_Q14;
                m.ent[8] = ONE_Q14;
                m.zero   = 1'b1;
                zero_noted++;
            end
            else begin
                num[0] = w*w + x*x - y*y - z*z;
                num[1] = 2 * (x*y - z*w);
                num[2] = 2 * (x*z + y*w);
                num[3] = 2 * (x*y + z*w);
                num[4] = w*w + y*y - x*x - z*z;
                num[5] = 2 * (y*z - x*w);
                num[6] = 2 * (x*z - y*w);
                num[7] = 2 * (y*z + x*w);
                num[8] = w*w + z*z - x*x - y*y;
                for (int k = 0; k < N_ENT; k++)
                    m.ent[k] = ratio_q14(num[k], nrm);
                m.zero = 1'b0;
            end
            pending_mats.push_back(m);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_matrix(logic [M_TDATA_W-1:0] data, logic user);
            rot_mat_t got;
            rot_mat_t want;
            got.ent  = data;
            got.zero = user;
            checked++;
            if (pending_mats.size() == 0) begin
                flag($sformatf("Matrix %0d arrived with no quaternion outstanding", checked));
                return;
            end
            want = pending_mats.pop_front();
            for (int k = 0; k < N_ENT; k++) begin
                if (got.ent[k] !== want.ent[k])
                    flag($sformatf("Matrix %0d r%0d%0d: expected %0d, got %0d", checked,
                                   k / 3, k % 3, $signed(want.ent[k]), $signed(got.ent[k])));
            end
            if (got.zero !== want.zero)
                flag($sformatf("Matrix %0d zero_norm: expected %0b, got %0b", checked,
                               want.zero, got.zero));
        endfunction
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_W-1:0]       s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int cycles        = 0;

    matrix_board board;

    quaternion_to_rotation_matrix #(
        .COMPONENT_BITS(COMP_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= (snk_stall_pct == 0) || ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_matrix(m_axis_tdata, m_axis_tuser);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_quat(s_axis_tdata);
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at cycle %0d with %0d matrices outstanding", cycles,
                     board.pending_mats.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [S_W-1:0] pack_quat(int x, int y, int z, int w);
        return {COMP_W'(w), COMP_W'(z), COMP_W'(y), COMP_W'(x)};
    endfunction

    function automatic logic [S_W-1:0] rand_quat();
        logic [COMP_W-1:0]        c[4];
        logic signed [COMP_W-1:0] tmp;
        int                       mode;
        int                       axis;
        mode = $urandom_range(0, 9);
        axis = $urandom_range(0, 4);
        for (int i = 0; i < 4; i++) begin
            case (mode)
                0, 1, 2: c[i] = COMP_W'($urandom());
                3:       c[i] = COMP_W'($urandom_range(0, 16) - 8);
                4:       c[i] = $urandom_range(0, 1) ? COMP_W'($urandom()) : '0;
                5: begin
                    case ($urandom_range(0, 5))
                        0:       c[i] = 16'h8000;
                        1:       c[i] = 16'h8001;
                        2:       c[i] = 16'hFFFF;
                        3:       c[i] = 16'h0000;
                        4:       c[i] = 16'h0001;
                        default: c[i] = 16'h7FFF;
                    endcase
                end
                // single axis, or the zero quaternion when axis is out of range
                6:       c[i] = (i == axis) ? COMP_W'($urandom()) : '0;
                default: begin
                    tmp  = COMP_W'($urandom());
                    c[i] = tmp >>> $urandom_range(0, 14);
                end
            endcase
        end
        return {c[3], c[2], c[1], c[0]};
    endfunction

    task automatic send_quat(input logic [S_W-1:0] d);
        @(negedge clk);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // drop valid and hold until every matrix has come back
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending_mats.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int count,
                             input bit hold_mid);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int i = 0; i < count; i++) begin
            if (hold_mid && i == count / 2)
                wait_drained();
            send_quat(rand_quat());
        end
    endtask

    initial
    begin
        board = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_quat(pack_quat(0, 0, 0, 0));
        send_quat(pack_quat(32767, 0, 0, 0));
        send_quat(pack_quat(0, 32767, 0, 0));
        send_quat(pack_quat(0, 0, 32767, 0));
        send_quat(pack_quat(0, 0, 0, 32767));
        send_quat(pack_quat(-32768, 0, 0, 0));
        send_quat(pack_quat(0, -32768, 0, 0));
        send_quat(pack_quat(0, 0, -32768, 0));
        send_quat(pack_quat(0, 0, 0, -32768));
        send_quat(pack_quat(-32768, -32768, -32768, -32768));
        send_quat(pack_quat(32767, 32767, 32767, 32767));
        send_quat(pack_quat(-32768, 32767, -32768, 32767));
        send_quat(pack_quat(1, 0, 0, 0));
        send_quat(pack_quat(0, 0, 0, -1));
        send_quat(pack_quat(1, 1, 1, 1));
        send_quat(pack_quat(-1, -1, -1, -1));
        send_quat(pack_quat(1, 1, 1, 0));
        send_quat(pack_quat(23170, 0, 0, 23170));
        send_quat(pack_quat(0, -23170, 0, 23170));
        send_quat(pack_quat(0, 0, 23170, -23170));
        send_quat(pack_quat(16384, -16384, 16384, -16384));
        send_quat(pack_quat(12345, -5432, 321, -30000));
        send_quat(pack_quat(0, 0, 0, 0));

        run_phase(0, 0, 130, 1'b0);
        run_phase(78, 0, 140, 1'b1);
        run_phase(0, 78, 140, 1'b0);
        run_phase(38, 38, 140, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d quaternions (%0d of zero norm) under free-running, idle-source,",
                 board.noted, board.zero_noted);
        $display("stalled-sink and mixed handshakes; %0d matrices checked, %0d mismatches",
                 board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending_mats.size() == 0) begin
            $display("Simulation PASSED");
        end
        else begin
            $display("%0d matrices never arrived", board.pending_mats.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
